// ----- sv/dsb_pkg.sv -----
// shared types, constants and the write-slot table of the dot splatter
package dsb_pkg;

  localparam int COORD_FRAC_BITS = 6;
  localparam int MAX_DIM         = 4096;

  localparam int POS_W  = 20;
  localparam int COL_W  = 16;
  localparam int PIX_W  = 12;
  localparam int DIM_W  = 13;
  localparam int WT_W   = 16;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 3;
  localparam int XW     = POS_W - COORD_FRAC_BITS + 1;
  localparam int CMP_W  = 17;
  localparam int WGT_W  = 17;
  localparam int C_W    = COL_W + WGT_W;
  localparam int P_W    = C_W + WT_W;
  localparam int MA_W   = C_W;
  localparam int MB_W   = WGT_W;
  localparam int PR_W   = MA_W + MB_W;
  localparam int RAW_W  = 2 * COORD_FRAC_BITS + 2;
  localparam int SH     = 2 * COORD_FRAC_BITS;
  localparam int Q_W    = 36;
  localparam int R_W    = 18;
  localparam int DIV_W  = 32;
  localparam int SLOT_W = 5;
  localparam int CNT_W  = 6;
  localparam int SUM_W  = P_W + 3;

  localparam logic [WGT_W-1:0] W_ONE = WGT_W'(65536);

  typedef enum logic [IDX_W-1:0] {
    REG_CANVAS_WIDTH    = 3'd0,
    REG_CANVAS_HEIGHT   = 3'd1,
    REG_STRAIGHT_WEIGHT = 3'd2,
    REG_DIAGONAL_WEIGHT = 3'd3,
    REG_ANTI_ALIAS      = 3'd4,
    REG_DE_TWIST        = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SQ, S_SQRT, S_DINIT, S_DIV, S_SCL, S_MUL, S_PUSH
  } front_state_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [WT_W-1:0]  straight;
    logic [WT_W-1:0]  diagonal;
    logic             anti_alias;
    logic             de_twist;
  } cfg_t;

  typedef struct packed {
    logic                    aa;
    logic signed [XW-1:0]    x;
    logic signed [XW-1:0]    y;
    logic [SLOT_W-1:0]       first;
    logic [SLOT_W-1:0]       last;
    logic [3:0][C_W-1:0]     c;
    logic [3:0][P_W-1:0]     tp;
    logic [3:0][P_W-1:0]     sp;
  } desc_t;

  typedef struct packed {
    logic              bil;
    logic [1:0]        ci;
    logic signed [2:0] dx;
    logic signed [2:0] dy;
    logic [3:0]        tm;
    logic [3:0]        sm;
  } slot_t;

  function automatic slot_t mk(logic bil, logic [1:0] ci, int dx, int dy,
                               logic [3:0] tm, logic [3:0] sm);
    slot_t s;
    s.bil = bil;
    s.ci  = ci;
    s.dx  = 3'(dx);
    s.dy  = 3'(dy);
    s.tm  = tm;
    s.sm  = sm;
    return s;
  endfunction

  // masks: bit 0 = a, 1 = b, 2 = c, 3 = d
  function automatic slot_t slot_of(logic aa, logic [SLOT_W-1:0] k);
    slot_t s;
    s = mk(1'b1, 2'd0, 0, 0, 4'b0000, 4'b0000);
    if (aa) begin
      case (k)
        5'd0:  s = mk(1'b1, 2'd0, 0, 0, 4'b0000, 4'b0000);
        5'd1:  s = mk(1'b1, 2'd1, 1, 0, 4'b0000, 4'b0000);
        5'd2:  s = mk(1'b1, 2'd2, 0, 1, 4'b0000, 4'b0000);
        5'd3:  s = mk(1'b1, 2'd3, 1, 1, 4'b0000, 4'b0000);
        5'd4:  s = mk(1'b0, 2'd0, -1, -1, 4'b0000, 4'b0001);
        5'd5:  s = mk(1'b0, 2'd0, 0, -1, 4'b0001, 4'b0010);
        5'd6:  s = mk(1'b0, 2'd0, 1, -1, 4'b0010, 4'b0001);
        5'd7:  s = mk(1'b0, 2'd0, 2, -1, 4'b0000, 4'b0010);
        5'd8:  s = mk(1'b0, 2'd0, -1, 0, 4'b0001, 4'b0100);
        5'd9:  s = mk(1'b0, 2'd0, 0, 0, 4'b0110, 4'b1000);
        5'd10: s = mk(1'b0, 2'd0, 1, 0, 4'b1001, 4'b0100);
        5'd11: s = mk(1'b0, 2'd0, 2, 0, 4'b0010, 4'b1000);
        5'd12: s = mk(1'b0, 2'd0, -1, 1, 4'b0100, 4'b0001);
        5'd13: s = mk(1'b0, 2'd0, 0, 1, 4'b1001, 4'b0010);
        5'd14: s = mk(1'b0, 2'd0, 1, 1, 4'b0110, 4'b0001);
        5'd15: s = mk(1'b0, 2'd0, 2, 1, 4'b1000, 4'b0010);
        5'd16: s = mk(1'b0, 2'd0, -1, 2, 4'b0000, 4'b0100);
        5'd17: s = mk(1'b0, 2'd0, 0, 2, 4'b0100, 4'b1000);
        5'd18: s = mk(1'b0, 2'd0, 1, 2, 4'b1000, 4'b0100);
        5'd19: s = mk(1'b0, 2'd0, 2, 2, 4'b0000, 4'b1000);
        default: s = mk(1'b1, 2'd0, 0, 0, 4'b0000, 4'b0000);
      endcase
    end else begin
      case (k)
        5'd0: s = mk(1'b1, 2'd0, 0, 0, 4'b0000, 4'b0000);
        5'd1: s = mk(1'b0, 2'd0, -1, -1, 4'b0000, 4'b0001);
        5'd2: s = mk(1'b0, 2'd0, 0, -1, 4'b0001, 4'b0000);
        5'd3: s = mk(1'b0, 2'd0, 1, -1, 4'b0000, 4'b0001);
        5'd4: s = mk(1'b0, 2'd0, -1, 0, 4'b0001, 4'b0000);
        5'd5: s = mk(1'b0, 2'd0, 1, 0, 4'b0001, 4'b0000);
        5'd6: s = mk(1'b0, 2'd0, -1, 1, 4'b0000, 4'b0001);
        5'd7: s = mk(1'b0, 2'd0, 0, 1, 4'b0001, 4'b0000);
        5'd8: s = mk(1'b0, 2'd0, 1, 1, 4'b0000, 4'b0001);
        default: s = mk(1'b1, 2'd0, 0, 0, 4'b0000, 4'b0000);
      endcase
    end
    return s;
  endfunction

endpackage

// ----- sv/dsb_front.sv -----
// front end: accepts dots, classifies them and builds the product set
module dsb_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dsb_pkg::cfg_t                       cfg,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [dsb_pkg::POS_W-1:0]    in_x_pos,
  input  logic signed [dsb_pkg::POS_W-1:0]    in_y_pos,
  input  logic [dsb_pkg::COL_W-1:0]           in_intensity,
  output logic                                push,
  input  logic                                q_full,
  output dsb_pkg::desc_t                      desc
);

  localparam int F = dsb_pkg::COORD_FRAC_BITS;
  localparam int XW = dsb_pkg::XW;
  localparam int CW = dsb_pkg::CMP_W;

  dsb_pkg::front_state_t state_r, state_nxt;
  dsb_pkg::desc_t desc_r;
  logic [dsb_pkg::CNT_W-1:0] cnt_r;
  logic [3:0][dsb_pkg::WGT_W-1:0] w_r;
  logic [dsb_pkg::COL_W-1:0] col_r;
  logic [dsb_pkg::Q_W-1:0] q_r, res_r, bit_r;
  logic [dsb_pkg::DIV_W-1:0] dn_r, dq_r;
  logic [dsb_pkg::R_W-1:0] rem_r;

  logic accept;
  logic [dsb_pkg::MA_W-1:0] ma;
  logic [dsb_pkg::MB_W-1:0] mb;
  logic [dsb_pkg::PR_W-1:0] prod;
  logic [dsb_pkg::WGT_W-1:0] sval;
  logic [dsb_pkg::R_W-1:0] rt;
  logic [dsb_pkg::R_W:0] dtmp;
  logic [dsb_pkg::Q_W-1:0] rb;

  // classification
  logic signed [XW-1:0] xf, yf, xr, yr, xs, ys;
  logic [dsb_pkg::POS_W-1:0] mx, my;
  logic [XW-2:0] rx, ry;
  logic signed [CW-1:0] xc, yc, wl, hl;
  logic ok0, nb;
  logic [F:0] fx, fy, ofx, ofy;
  logic [3:0][dsb_pkg::RAW_W-1:0] raw;
  logic [3:0][dsb_pkg::WGT_W-1:0] wi;

  assign accept = in_valid && in_ready;
  assign rt = res_r[dsb_pkg::R_W-1:0];
  assign sval = (rt == '0) ? dsb_pkg::W_ONE : dq_r[dsb_pkg::WGT_W-1:0];
  assign rb = res_r + bit_r;
  assign dtmp = {rem_r, dn_r[dsb_pkg::DIV_W-1]};

  always_comb begin
    xf = XW'(in_x_pos >>> F);
    yf = XW'(in_y_pos >>> F);
    mx = in_x_pos[dsb_pkg::POS_W-1] ? dsb_pkg::POS_W'(-in_x_pos) : in_x_pos;
    my = in_y_pos[dsb_pkg::POS_W-1] ? dsb_pkg::POS_W'(-in_y_pos) : in_y_pos;
    rx = (XW-1)'(((dsb_pkg::POS_W+1)'(mx) + (dsb_pkg::POS_W+1)'(1 << (F-1))) >> F);
    ry = (XW-1)'(((dsb_pkg::POS_W+1)'(my) + (dsb_pkg::POS_W+1)'(1 << (F-1))) >> F);
    xr = in_x_pos[dsb_pkg::POS_W-1] ? -$signed({1'b0, rx}) : $signed({1'b0, rx});
    yr = in_y_pos[dsb_pkg::POS_W-1] ? -$signed({1'b0, ry}) : $signed({1'b0, ry});
    xs = cfg.anti_alias ? xf : xr;
    ys = cfg.anti_alias ? yf : yr;
    xc = CW'(xs);
    yc = CW'(ys);
    wl = (cfg.width > dsb_pkg::DIM_W'(dsb_pkg::MAX_DIM)) ? CW'(dsb_pkg::MAX_DIM)
                                                         : CW'({1'b0, cfg.width});
    hl = (cfg.height > dsb_pkg::DIM_W'(dsb_pkg::MAX_DIM)) ? CW'(dsb_pkg::MAX_DIM)
                                                          : CW'({1'b0, cfg.height});
    if (cfg.anti_alias) begin
      ok0 = (xc >= 0) && (xc < wl - 1) && (yc >= 0) && (yc < hl - 1);
      nb = (cfg.straight != '0) && (xc >= 1) && (xc < wl - 2) &&
           (yc >= 1) && (yc < hl - 2);
    end else begin
      ok0 = (xc >= 0) && (xc < wl) && (yc >= 0) && (yc < hl);
      nb = (cfg.straight != '0) && (xc >= 1) && (xc < wl - 1) &&
           (yc >= 1) && (yc < hl - 1);
    end
    fx = {1'b0, in_x_pos[F-1:0]};
    fy = {1'b0, in_y_pos[F-1:0]};
    ofx = (F+1)'(1 << F) - fx;
    ofy = (F+1)'(1 << F) - fy;
    raw[0] = dsb_pkg::RAW_W'(ofx * ofy);
    raw[1] = dsb_pkg::RAW_W'(fx * ofy);
    raw[2] = dsb_pkg::RAW_W'(ofx * fy);
    raw[3] = dsb_pkg::RAW_W'(fx * fy);
    for (int i = 0; i < 4; i++) begin
      wi[i] = dsb_pkg::WGT_W'((((dsb_pkg::RAW_W+17)'(raw[i]) << 16) +
               (dsb_pkg::RAW_W+17)'(1 << (dsb_pkg::SH-1))) >> dsb_pkg::SH);
    end
  end

  // shared multiplier operands
  always_comb begin
    ma = '0;
    mb = '0;
    case (state_r)
      dsb_pkg::S_SQ: begin
        ma = dsb_pkg::MA_W'(w_r[cnt_r[1:0]]);
        mb = w_r[cnt_r[1:0]];
      end
      dsb_pkg::S_SCL: begin
        ma = dsb_pkg::MA_W'(w_r[cnt_r[1:0]]);
        mb = sval;
      end
      dsb_pkg::S_MUL: begin
        if (cnt_r < 4) begin
          ma = dsb_pkg::MA_W'(w_r[cnt_r[1:0]]);
          mb = dsb_pkg::MB_W'(col_r);
        end else if (cnt_r < 8) begin
          ma = desc_r.c[cnt_r[1:0]];
          mb = dsb_pkg::MB_W'(cfg.straight);
        end else begin
          ma = desc_r.c[cnt_r[1:0]];
          mb = dsb_pkg::MB_W'(cfg.diagonal);
        end
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod = dsb_pkg::PR_W'(ma) * dsb_pkg::PR_W'(mb);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dsb_pkg::S_IDLE: begin
        if (accept && (ok0 || nb)) begin
          state_nxt = (cfg.anti_alias && cfg.de_twist) ? dsb_pkg::S_SQ : dsb_pkg::S_MUL;
        end
      end
      dsb_pkg::S_SQ:    if (cnt_r == 3) state_nxt = dsb_pkg::S_SQRT;
      dsb_pkg::S_SQRT:  if (cnt_r == dsb_pkg::CNT_W'(dsb_pkg::R_W - 1))
                          state_nxt = dsb_pkg::S_DINIT;
      dsb_pkg::S_DINIT: state_nxt = dsb_pkg::S_DIV;
      dsb_pkg::S_DIV:   if (cnt_r == dsb_pkg::CNT_W'(dsb_pkg::DIV_W - 1))
                          state_nxt = dsb_pkg::S_SCL;
      dsb_pkg::S_SCL:   if (cnt_r == 3) state_nxt = dsb_pkg::S_MUL;
      dsb_pkg::S_MUL:   if (cnt_r == 11) state_nxt = dsb_pkg::S_PUSH;
      dsb_pkg::S_PUSH:  if (!q_full) state_nxt = dsb_pkg::S_IDLE;
      default:          state_nxt = dsb_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state_r == dsb_pkg::S_IDLE);
    push = (state_r == dsb_pkg::S_PUSH) && !q_full;
    desc = desc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dsb_pkg::S_IDLE;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_nxt != state_r) cnt_r <= '0;
      else cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      dsb_pkg::S_IDLE: begin
        if (accept) begin
          desc_r.aa <= cfg.anti_alias;
          desc_r.x <= xs;
          desc_r.y <= ys;
          col_r <= in_intensity;
          q_r <= '0;
          if (cfg.anti_alias) begin
            desc_r.first <= ok0 ? 5'd0 : 5'd4;
            desc_r.last <= nb ? 5'd19 : 5'd3;
            w_r <= wi;
          end else begin
            desc_r.first <= ok0 ? 5'd0 : 5'd1;
            desc_r.last <= nb ? 5'd8 : 5'd0;
            // centre weight of one makes every neighbour a single product
            w_r <= {{(3*dsb_pkg::WGT_W){1'b0}}, dsb_pkg::W_ONE};
          end
        end
      end
      dsb_pkg::S_SQ: begin
        q_r <= q_r + dsb_pkg::Q_W'(prod);
        res_r <= '0;
        bit_r <= dsb_pkg::Q_W'(1) << (2 * (dsb_pkg::R_W - 1));
      end
      dsb_pkg::S_SQRT: begin
        if (q_r >= rb) begin
          q_r <= q_r - rb;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      dsb_pkg::S_DINIT: begin
        dn_r <= dsb_pkg::DIV_W'(33'h080000000 + 33'(rt >> 1));
        rem_r <= '0;
        dq_r <= '0;
      end
      dsb_pkg::S_DIV: begin
        dn_r <= dn_r << 1;
        if (dtmp >= {1'b0, rt}) begin
          rem_r <= dsb_pkg::R_W'(dtmp - {1'b0, rt});
          dq_r <= {dq_r[dsb_pkg::DIV_W-2:0], 1'b1};
        end else begin
          rem_r <= dtmp[dsb_pkg::R_W-1:0];
          dq_r <= {dq_r[dsb_pkg::DIV_W-2:0], 1'b0};
        end
      end
      dsb_pkg::S_SCL: begin
        w_r[cnt_r[1:0]] <= dsb_pkg::WGT_W'((prod + dsb_pkg::PR_W'(32768)) >> 16);
      end
      dsb_pkg::S_MUL: begin
        if (cnt_r < 4) desc_r.c[cnt_r[1:0]] <= prod[dsb_pkg::C_W-1:0];
        else if (cnt_r < 8) desc_r.tp[cnt_r[1:0]] <= prod[dsb_pkg::P_W-1:0];
        else desc_r.sp[cnt_r[1:0]] <= prod[dsb_pkg::P_W-1:0];
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- sv/dsb_queue.sv -----
// two-entry queue of dot descriptors between front and back
module dsb_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dsb_pkg::desc_t wdata,
  input  logic           pop,
  output logic           full,
  output logic           nonempty,
  output dsb_pkg::desc_t rdata
);

  dsb_pkg::desc_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full = (cnt_r == 2'd2);
  assign nonempty = (cnt_r != 2'd0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

// ----- sv/dsb_back.sv -----
// back end: walks the write slots of a dot and drives the output register
module dsb_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_nonempty,
  input  dsb_pkg::desc_t                 head,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [dsb_pkg::PIX_W-1:0]      out_pixel_x,
  output logic [dsb_pkg::PIX_W-1:0]      out_pixel_y,
  output logic [dsb_pkg::COL_W-1:0]      out_amount,
  output logic                           out_last_write
);

  logic started_r, valid_r;
  logic [dsb_pkg::SLOT_W-1:0] k_r, k;
  dsb_pkg::slot_t sl;
  logic advance, is_last;
  logic [dsb_pkg::SUM_W-1:0] sum;
  logic [dsb_pkg::SUM_W-1:0] amt;
  logic [dsb_pkg::PIX_W-1:0] px_r, py_r;
  logic [dsb_pkg::COL_W-1:0] amt_r;
  logic last_r;

  assign k = started_r ? k_r : head.first;
  assign sl = dsb_pkg::slot_of(head.aa, k);
  assign advance = q_nonempty && (!valid_r || out_ready);
  assign is_last = (k == head.last);
  assign pop = advance && is_last;

  always_comb begin
    sum = dsb_pkg::SUM_W'(64'h80000000);
    for (int i = 0; i < 4; i++) begin
      if (sl.tm[i]) sum = sum + dsb_pkg::SUM_W'(head.tp[i]);
      if (sl.sm[i]) sum = sum + dsb_pkg::SUM_W'(head.sp[i]);
    end
    if (sl.bil) amt = dsb_pkg::SUM_W'((head.c[sl.ci] + dsb_pkg::C_W'(32768)) >> 16);
    else amt = sum >> 32;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      valid_r <= 1'b0;
      k_r <= '0;
    end else begin
      if (advance) begin
        valid_r <= 1'b1;
        started_r <= !is_last;
        k_r <= k + 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      px_r <= dsb_pkg::PIX_W'(head.x + dsb_pkg::XW'(sl.dx));
      py_r <= dsb_pkg::PIX_W'(head.y + dsb_pkg::XW'(sl.dy));
      amt_r <= (amt > dsb_pkg::SUM_W'(65535)) ? 16'hFFFF : amt[dsb_pkg::COL_W-1:0];
      last_r <= is_last;
    end
  end

  assign out_valid = valid_r;
  assign out_pixel_x = px_r;
  assign out_pixel_y = py_r;
  assign out_amount = amt_r;
  assign out_last_write = last_r;

endmodule

// ----- sv/dot_splat_bilinear_3x3.sv -----
// top level of the dot splatter: configuration registers, front, queue and back
//
// Each dot word in becomes up to twenty pixel words out, one per cycle
// unless out_ready stalls: four bilinear pixels plus sixteen kernel sums in
// anti-aliased mode, a centre pixel plus eight neighbours in rounded mode;
// dots off the canvas give none. The front takes a dot, classifies it and
// forms all weight products on one shared multiplier, so it cannot take the
// next dot until the current one is pushed (de-twist adds 4 squares, an
// 18-step square root, a divide setup step, a 32-step divide and 4 rescales);
// a two-deep queue lets the next dot be prepared while the back streams the
// current one, so the back sets the output rate at one write per cycle while
// out_ready holds, and the front sets it when de-twist is on.
module dot_splat_bilinear_3x3 (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [dsb_pkg::IDX_W-1:0]         cfg_index,
  input  logic [dsb_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [dsb_pkg::POS_W-1:0]  in_x_pos,
  input  logic signed [dsb_pkg::POS_W-1:0]  in_y_pos,
  input  logic [dsb_pkg::COL_W-1:0]         in_intensity,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dsb_pkg::PIX_W-1:0]         out_pixel_x,
  output logic [dsb_pkg::PIX_W-1:0]         out_pixel_y,
  output logic [dsb_pkg::COL_W-1:0]         out_amount,
  output logic                              out_last_write
);

  dsb_pkg::cfg_t cfg_r;
  dsb_pkg::desc_t f_desc, q_head;
  logic push, pop, q_full, q_nonempty;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width <= dsb_pkg::DIM_W'(1024);
      cfg_r.height <= dsb_pkg::DIM_W'(1024);
      cfg_r.straight <= '0;
      cfg_r.diagonal <= '0;
      cfg_r.anti_alias <= 1'b1;
      cfg_r.de_twist <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        dsb_pkg::REG_CANVAS_WIDTH:    cfg_r.width <= cfg_data[dsb_pkg::DIM_W-1:0];
        dsb_pkg::REG_CANVAS_HEIGHT:   cfg_r.height <= cfg_data[dsb_pkg::DIM_W-1:0];
        dsb_pkg::REG_STRAIGHT_WEIGHT: cfg_r.straight <= cfg_data;
        dsb_pkg::REG_DIAGONAL_WEIGHT: cfg_r.diagonal <= cfg_data;
        dsb_pkg::REG_ANTI_ALIAS:      cfg_r.anti_alias <= cfg_data[0];
        dsb_pkg::REG_DE_TWIST:        cfg_r.de_twist <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // classify and build products
  dsb_front u_front (
    .clk, .rst_n, .cfg(cfg_r),
    .in_valid, .in_ready, .in_x_pos, .in_y_pos, .in_intensity,
    .push, .q_full, .desc(f_desc)
  );

  // decouples product building from pixel streaming
  dsb_queue u_queue (
    .clk, .rst_n, .push, .wdata(f_desc), .pop,
    .full(q_full), .nonempty(q_nonempty), .rdata(q_head)
  );

  // one pixel word per cycle through the output register while out_ready holds
  dsb_back u_back (
    .clk, .rst_n, .q_nonempty, .head(q_head), .pop,
    .out_valid, .out_ready, .out_pixel_x, .out_pixel_y,
    .out_amount, .out_last_write
  );

endmodule

// ----- dv/tb_dot_splat_bilinear_3x3.sv -----
// self-checking testbench for the dot splatter: directed and random dots, scoreboard check
`timescale 1ns / 1ps

module tb_dot_splat_bilinear_3x3;

  typedef longint unsigned u64;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 120;  // covers the longest front hold, with de-twist

  // one expected pixel word
  typedef struct {
    logic [dsb_pkg::PIX_W-1:0] px;
    logic [dsb_pkg::PIX_W-1:0] py;
    logic [dsb_pkg::COL_W-1:0] amount;
    logic                      last;
  } pix_write_t;

  // predicts the pixel writes of each dot and checks the words that come out
  class splat_scoreboard;
    int unsigned width = 1024, height = 1024;
    u64 straight_w = 0, diagonal_w = 0;
    bit aa_mode = 1, detwist = 0;
    pix_write_t expected_writes[$];
    pix_write_t dot_writes[$];
    int n_bad = 0;

    function void set_reg(dsb_pkg::reg_idx_t idx, int unsigned v);
      case (idx)
        dsb_pkg::REG_CANVAS_WIDTH:    width = v & 13'h1fff;
        dsb_pkg::REG_CANVAS_HEIGHT:   height = v & 13'h1fff;
        dsb_pkg::REG_STRAIGHT_WEIGHT: straight_w = v & 16'hffff;
        dsb_pkg::REG_DIAGONAL_WEIGHT: diagonal_w = v & 16'hffff;
        dsb_pkg::REG_ANTI_ALIAS:      aa_mode = v[0];
        dsb_pkg::REG_DE_TWIST:        detwist = v[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_writes.size();
    endfunction

    function u64 int_sqrt(u64 v);
      u64 res, bit_v;
      res = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > v) bit_v >>= 2;
      while (bit_v != 0) begin
        if (v >= res + bit_v) begin
          v -= res + bit_v;
          res = (res >> 1) + bit_v;
        end else begin
          res >>= 1;
        end
        bit_v >>= 2;
      end
      return res;
    endfunction

    function void add_write(int x, int y, u64 amt);
      pix_write_t w;
      w.px = dsb_pkg::PIX_W'(x);
      w.py = dsb_pkg::PIX_W'(y);
      w.amount = (amt > 65535) ? 16'hffff : dsb_pkg::COL_W'(amt);
      w.last = 1'b0;
      dot_writes.push_back(w);
    endfunction

    function int round_coord(int p);
      int unsigned m, r;
      m = (p < 0) ? -p : p;
      r = (m + 32) >> dsb_pkg::COORD_FRAC_BITS;
      return (p < 0) ? -int'(r) : int'(r);
    endfunction

    function void note_dot(logic signed [dsb_pkg::POS_W-1:0] xp,
                           logic signed [dsb_pkg::POS_W-1:0] yp,
                           logic [dsb_pkg::COL_W-1:0] intensity);
      int px, py, wi, hi, x, y, xi, yi, i;
      int unsigned fx, fy;
      u64 col, ta, sa, q, r, sc, h;
      u64 raw[4], wt[4], c[4], tp[4], sp[4];
      px = xp;
      py = yp;
      col = intensity;
      wi = (width > dsb_pkg::MAX_DIM) ? dsb_pkg::MAX_DIM : width;
      hi = (height > dsb_pkg::MAX_DIM) ? dsb_pkg::MAX_DIM : height;
      dot_writes.delete();
      if (!aa_mode) begin
        x = round_coord(px);
        y = round_coord(py);
        if (x >= 0 && x < wi && y >= 0 && y < hi) add_write(x, y, col);
        // thickness ring only for interior dots
        if (straight_w != 0 && x >= 1 && x < wi - 1 && y >= 1 && y < hi - 1) begin
          ta = (col * straight_w + 32768) >> 16;
          sa = (col * diagonal_w + 32768) >> 16;
          add_write(x - 1, y - 1, sa); add_write(x, y - 1, ta); add_write(x + 1, y - 1, sa);
          add_write(x - 1, y, ta);     add_write(x + 1, y, ta);
          add_write(x - 1, y + 1, sa); add_write(x, y + 1, ta); add_write(x + 1, y + 1, sa);
        end
      end else begin
        fx = px & 63;
        fy = py & 63;
        xi = px >>> dsb_pkg::COORD_FRAC_BITS;
        yi = py >>> dsb_pkg::COORD_FRAC_BITS;
        raw[0] = u64'(64 - fx) * u64'(64 - fy);
        raw[1] = u64'(fx) * u64'(64 - fy);
        raw[2] = u64'(64 - fx) * u64'(fy);
        raw[3] = u64'(fx) * u64'(fy);
        for (i = 0; i < 4; i++)
          wt[i] = ((raw[i] << 16) + (64'd1 << (dsb_pkg::SH - 1))) >> dsb_pkg::SH;
        if (detwist) begin
          q = wt[0] * wt[0] + wt[1] * wt[1] + wt[2] * wt[2] + wt[3] * wt[3];
          r = int_sqrt(q);
          sc = (r == 0) ? 64'd65536 : ((64'd1 << 31) + (r >> 1)) / r;
          for (i = 0; i < 4; i++) wt[i] = (wt[i] * sc + 32768) >> 16;
        end
        for (i = 0; i < 4; i++) begin
          c[i] = col * wt[i];
          tp[i] = straight_w * c[i];
          sp[i] = diagonal_w * c[i];
        end
        if (xi >= 0 && xi < wi - 1 && yi >= 0 && yi < hi - 1) begin
          add_write(xi, yi, (c[0] + 32768) >> 16);
          add_write(xi + 1, yi, (c[1] + 32768) >> 16);
          add_write(xi, yi + 1, (c[2] + 32768) >> 16);
          add_write(xi + 1, yi + 1, (c[3] + 32768) >> 16);
        end
        // sixteen kernel sums over the 4x4 block, row by row
        if (straight_w != 0 && xi >= 1 && xi < wi - 2 && yi >= 1 && yi < hi - 2) begin
          h = 64'd1 << 31;
          add_write(xi - 1, yi - 1, (sp[0] + h) >> 32);
          add_write(xi,     yi - 1, (tp[0] + sp[1] + h) >> 32);
          add_write(xi + 1, yi - 1, (tp[1] + sp[0] + h) >> 32);
          add_write(xi + 2, yi - 1, (sp[1] + h) >> 32);
          add_write(xi - 1, yi,     (tp[0] + sp[2] + h) >> 32);
          add_write(xi,     yi,     (sp[3] + tp[1] + tp[2] + h) >> 32);
          add_write(xi + 1, yi,     (sp[2] + tp[0] + tp[3] + h) >> 32);
          add_write(xi + 2, yi,     (tp[1] + sp[3] + h) >> 32);
          add_write(xi - 1, yi + 1, (tp[2] + sp[0] + h) >> 32);
          add_write(xi,     yi + 1, (sp[1] + tp[0] + tp[3] + h) >> 32);
          add_write(xi + 1, yi + 1, (sp[0] + tp[1] + tp[2] + h) >> 32);
          add_write(xi + 2, yi + 1, (tp[3] + sp[1] + h) >> 32);
          add_write(xi - 1, yi + 2, (sp[2] + h) >> 32);
          add_write(xi,     yi + 2, (tp[2] + sp[3] + h) >> 32);
          add_write(xi + 1, yi + 2, (tp[3] + sp[2] + h) >> 32);
          add_write(xi + 2, yi + 2, (sp[3] + h) >> 32);
        end
      end
      if (dot_writes.size() > 0) dot_writes[dot_writes.size() - 1].last = 1'b1;
      foreach (dot_writes[k]) expected_writes.push_back(dot_writes[k]);
    endfunction

    function void check_write(logic [dsb_pkg::PIX_W-1:0] px, logic [dsb_pkg::PIX_W-1:0] py,
                              logic [dsb_pkg::COL_W-1:0] amount, logic last);
      pix_write_t e;
      if (expected_writes.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("unexpected word: x=%0d y=%0d amount=%0d last=%0b", px, py, amount, last);
        return;
      end
      e = expected_writes.pop_front();
      if (px !== e.px || py !== e.py || amount !== e.amount || last !== e.last) begin
        n_bad++;
        if (n_bad <= 10)
          $display({"bad word: exp x=%0d y=%0d amount=%0d last=%0b, ",
                    "got x=%0d y=%0d amount=%0d last=%0b"},
                   e.px, e.py, e.amount, e.last, px, py, amount, last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [dsb_pkg::IDX_W-1:0] cfg_index = '0;
  logic [dsb_pkg::CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [dsb_pkg::POS_W-1:0] in_x_pos = '0;
  logic signed [dsb_pkg::POS_W-1:0] in_y_pos = '0;
  logic [dsb_pkg::COL_W-1:0] in_intensity = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [dsb_pkg::PIX_W-1:0] out_pixel_x;
  logic [dsb_pkg::PIX_W-1:0] out_pixel_y;
  logic [dsb_pkg::COL_W-1:0] out_amount;
  logic out_last_write;

  splat_scoreboard sb = new();
  int cycle_count = 0;
  bit quiet_out = 0;   // no stalls on the result side while set
  bit quiet_in = 0;    // no gaps between dots while set

  dot_splat_bilinear_3x3 DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_x_pos(in_x_pos), .in_y_pos(in_y_pos), .in_intensity(in_intensity),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pixel_x(out_pixel_x), .out_pixel_y(out_pixel_y),
    .out_amount(out_amount), .out_last_write(out_last_write)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("dot_splat_bilinear_3x3: mismatch");
      $finish;
    end
  end

  // result side: check every accepted pixel word
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_write(out_pixel_x, out_pixel_y, out_amount, out_last_write);
  end

  // result side backpressure: mostly short stalls, now and then a long one
  initial begin : ready_driver
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
        if (!quiet_out && $urandom_range(0, 3) == 0)
          stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 40)
                                                    : $urandom_range(1, 3);
      end
    end
  end

  function automatic int dot_gap();
    if (quiet_in || $urandom_range(0, 9) < 5) return 0;
    if ($urandom_range(0, 9) < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // drive one dot word, hold it until accepted, then maybe idle a while
  task automatic send_dot(int x, int y, int intensity);
    int gap;
    @(negedge clk);
    in_valid = 1'b1;
    in_x_pos = dsb_pkg::POS_W'(x);
    in_y_pos = dsb_pkg::POS_W'(y);
    in_intensity = dsb_pkg::COL_W'(intensity);
    do @(posedge clk); while (!in_ready);
    sb.note_dot(in_x_pos, in_y_pos, in_intensity);
    gap = dot_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // let all expected words arrive and the front finish dots that make none
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(dsb_pkg::reg_idx_t idx, int unsigned v);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = dsb_pkg::CFG_W'(v);
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic write_all(int unsigned w, int unsigned h, int unsigned t, int unsigned d,
                           bit aa, bit dt);
    wait_idle();
    write_reg(dsb_pkg::REG_CANVAS_WIDTH, w);
    write_reg(dsb_pkg::REG_CANVAS_HEIGHT, h);
    write_reg(dsb_pkg::REG_STRAIGHT_WEIGHT, t);
    write_reg(dsb_pkg::REG_DIAGONAL_WEIGHT, d);
    write_reg(dsb_pkg::REG_ANTI_ALIAS, aa);
    write_reg(dsb_pkg::REG_DE_TWIST, dt);
  endtask

  function automatic int unsigned pick_dim();
    case ($urandom_range(0, 6))
      0: return 3;
      1: return 4;
      2, 3: return $urandom_range(5, 40);
      4: return 4096;
      5: return 8191;
      default: return $urandom_range(3, 4096);
    endcase
  endfunction

  function automatic int unsigned pick_weight();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return 65535;
      default: return $urandom_range(1, 65535);
    endcase
  endfunction

  // mostly positions on or near the canvas, some anywhere in the 20-bit range
  function automatic int pick_pos(int unsigned dim);
    int d, p;
    if ($urandom_range(0, 4) == 0) return $urandom();
    d = (dim > dsb_pkg::MAX_DIM) ? dsb_pkg::MAX_DIM : dim;
    case ($urandom_range(0, 3))
      0: p = $urandom_range(0, 4) - 2;
      1: p = d - 3 + $urandom_range(0, 4);
      default: p = $urandom_range(0, d + 3) - 2;
    endcase
    return p * 64 + $urandom_range(0, 63);
  endfunction

  function automatic int pick_intensity();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 65535;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  initial begin : stimulus
    int n_phase;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: bilinear, no thickness, 1024 x 1024
    quiet_in = 1;
    send_dot(0, 0, 65535);                           // whole weight on one pixel
    send_dot(63, 63, 65535);                         // largest fractions
    send_dot(1022 * 64 + 63, 1022 * 64 + 63, 1000);  // last bilinear position
    send_dot(1023 * 64, 0, 500);                     // off the right edge
    send_dot(-1, -1, 700);                           // floors to -1, off canvas
    send_dot(524287, -524288, 0);                    // extreme positions
    quiet_in = 0;

    // rounded mode on a 3 x 3 canvas, full weights
    write_all(3, 3, 65535, 65535, 0, 0);
    send_dot(64, 64, 65535);    // interior: centre plus ring
    send_dot(-32, 64, 100);     // -0.5 rounds away to -1, off canvas
    send_dot(31, 31, 200);      // rounds down to the corner, centre only
    send_dot(159, 159, 300);    // rounds to 2, edge centre only
    send_dot(160, 160, 400);    // 2.5 rounds up to 3, off canvas
    send_dot(-31, 0, 65535);

    // oversize canvas acts as the maximum, de-twist on
    write_all(8191, 8191, 1, 0, 1, 1);
    send_dot(64 * 100 + 17, 64 * 200 + 45, 65535);
    send_dot(64 * 4093 + 63, 64 * 4093 + 63, 40000);
    send_dot(64 * 4094, 64, 40000);   // past the kernel-sum bound, still bilinear
    send_dot(65, 65, 12345);
    send_dot(128, 128, 65535);        // zero fractions under de-twist

    // zero canvas: nothing passes the bounds
    write_all(0, 0, 65535, 65535, 1, 0);
    send_dot(0, 0, 1000);
    // diagonal without straight weight, wide flat canvas
    write_all(4096, 5, 0, 65535, 0, 0);
    send_dot(64 * 4095, 64 * 2, 1234);
    write_all(4096, 5, 65535, 0, 1, 0);
    send_dot(64 * 4093 + 5, 64 * 2 + 60, 65535);

    // random phases
    n_phase = 0;
    while (n_phase < 9) begin
      write_all(pick_dim(), pick_dim(), pick_weight(), pick_weight(),
                $urandom_range(0, 9) < 7, $urandom_range(0, 9) < 4);
      quiet_in = (n_phase % 4 == 1);
      quiet_out = (n_phase % 4 == 2);
      repeat (10)
        send_dot(pick_pos(sb.width), pick_pos(sb.height), pick_intensity());
      n_phase++;
    end
    quiet_in = 0;
    quiet_out = 0;

    wait_idle();
    if (sb.n_bad == 0 && sb.pending() == 0) begin
      $display("dot_splat_bilinear_3x3: match");
    end else begin
      $display("dot_splat_bilinear_3x3: mismatch");
    end
    $finish;
  end

endmodule
